/* rtl/core/scm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scm_pkg
// shared types and constants of the scheduled clip mixer
// ----------------------------------------------------------------------------
package scm_pkg;

  localparam int SampleW = 24;
  localparam int FrameW  = 40;
  localparam int LenW    = 16;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_CLIP   = 2'd1,
    KIND_EVENT  = 2'd2,
    KIND_RENDER = 2'd3
  } kind_t;

  // request from the sequencer to the fade divider
  typedef struct packed {
    logic                start;
    logic [SampleW-1:0]  mag;
    logic [LenW-1:0]     num;
    logic [LenW-1:0]     den;
  } div_req_t;

endpackage
`default_nettype wire

/* rtl/core/scm_fade_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scm_fade_div
// rounded mag*num/den, one quotient bit per cycle (restoring division)
// ----------------------------------------------------------------------------
module scm_fade_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire scm_pkg::div_req_t req,
  output logic                   done,
  output logic [40:0]            quot
);
  import scm_pkg::*;

  localparam int DividendW = 41;  // 2*mag*num + den < 2^41
  localparam int CntW = 6;

  logic [DividendW-1:0] dvd_r, dvd_nxt;
  logic [17:0]          dvs_r, dvs_nxt;
  logic [17:0]          rem_r, rem_nxt;
  logic [CntW-1:0]      cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [39:0]          prod;
  logic [18:0]          trial;

  assign prod = 40'(req.mag) * 40'(req.num);

  always_comb begin
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, dvd_r[DividendW-1]};
    if (req.start) begin
      dvd_nxt  = {prod, 1'b0} + DividendW'(req.den);
      dvs_nxt  = {1'b0, req.den, 1'b0};
      rem_nxt  = '0;
      cnt_nxt  = CntW'(DividendW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= 19'(dvs_r)) begin
        rem_nxt = 18'(trial - 19'(dvs_r));
        dvd_nxt = {dvd_r[DividendW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[17:0];
        dvd_nxt = {dvd_r[DividendW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quot = dvd_r;

endmodule
`default_nettype wire

/* rtl/core/scheduled_clip_mixer_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scheduled_clip_mixer_top
// sample, clip and event memories with a slot-serial mixing sequencer
// ----------------------------------------------------------------------------
// load transactions are taken while idle; a render raises out_valid after an event
// read, clip read and check per event slot, a sample read and add per output channel
// of each sounding slot, a serial divide per faded term and any wait for a busy output
// one transaction is in work at a time; loads pass while a result waits
// reset clears the enable bits of all event slots; other memories are
// undefined until written
module scheduled_clip_mixer_top #(
  parameter int EVENT_SLOTS  = 16,
  parameter int CLIP_SLOTS   = 16,
  parameter int SAMPLE_WORDS = 65536,
  parameter int OUT_CHANNELS = 2
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             in_kind,
  input  wire logic [15:0]            in_index,
  input  wire logic signed [23:0]     in_sample_value,
  input  wire logic [15:0]            in_clip_base,
  input  wire logic [15:0]            in_clip_frames,
  input  wire logic [1:0]             in_clip_channels,
  input  wire logic [39:0]            in_event_start,
  input  wire logic [15:0]            in_event_max_frames,
  input  wire logic [15:0]            in_event_fade_frames,
  input  wire logic [3:0]             in_event_clip,
  input  wire logic                   in_event_enable,
  input  wire logic [39:0]            in_frame_number,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic signed [23:0]          out_mix_left,
  output logic signed [23:0]          out_mix_right,
  output logic                        out_saturated
);
  import scm_pkg::*;

  localparam int EvW  = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
  localparam int ClW  = (CLIP_SLOTS > 1) ? $clog2(CLIP_SLOTS) : 1;
  localparam int AdrW = $clog2(SAMPLE_WORDS);
  localparam int AccW = 34;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_EVRD  = 8'b0000_0010,
    ST_CLRD  = 8'b0000_0100,
    ST_CHECK = 8'b0000_1000,
    ST_SMPRD = 8'b0001_0000,
    ST_ADD   = 8'b0010_0000,
    ST_DIV   = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_t;

  // memories
  logic [SampleW-1:0] smp_mem [SAMPLE_WORDS];
  logic [33:0]        clip_mem [CLIP_SLOTS];
  logic [39:0]        evs_mem [EVENT_SLOTS];
  logic [36:0]        evp_mem [EVENT_SLOTS];
  logic [EVENT_SLOTS-1:0] en_r;

  logic [SampleW-1:0] smp_q_r;
  logic [33:0]        clip_q_r;
  logic [39:0]        evs_q_r;
  logic [36:0]        evp_q_r;
  logic               en_q_r;

  logic [AdrW-1:0]    smp_ra;
  logic [ClW-1:0]     clip_ra;

  state_t state_r, state_nxt;
  logic [EvW-1:0]     slot_r, slot_nxt;
  logic               ch_r, ch_nxt;
  logic [39:0]        frame_r;
  logic [15:0]        pos_r, pos_nxt;
  logic [15:0]        len_r, len_nxt;
  logic [15:0]        flen_r, flen_nxt;
  logic               fading_r, fading_nxt;
  logic [AccW-1:0]    acc_l_r, acc_l_nxt, acc_r_r, acc_r_nxt;
  logic               out_valid_r;
  logic [23:0]        out_l_r, out_r_r;
  logic               out_sat_r;

  div_req_t           dreq;
  logic               ddone;
  logic [40:0]        dquot;

  logic               acc_in;
  logic               out_load;
  logic               last_slot;
  logic [15:0]        ev_max, ev_fade, cl_frames, cl_base;
  logic [3:0]         ev_clip;
  logic [1:0]         cl_chan;
  logic [1:0]         stride;
  logic [15:0]        len_c;
  logic [40:0]        diff;
  logic [AccW-1:0]    term;
  logic               sneg;
  logic [23:0]        smag;
  logic               sel_ch;
  logic [AccW-1:0]    dq_s;
  logic               sat_l, sat_r;
  logic [23:0]        fin_l, fin_r;
  logic [31:0]        addr_full;

  assign acc_in = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);
  assign last_slot = (32'(slot_r) == EVENT_SLOTS - 1);

  assign ev_max    = evp_q_r[36:21];
  assign ev_fade   = evp_q_r[20:5];
  assign ev_clip   = evp_q_r[4:1];
  assign cl_base   = clip_q_r[33:18];
  assign cl_frames = clip_q_r[17:2];
  assign cl_chan   = clip_q_r[1:0];
  assign stride    = (cl_chan == 2'd0) ? 2'd1 : cl_chan;
  assign len_c     = (ev_max != 16'd0 && ev_max < cl_frames) ? ev_max : cl_frames;
  assign diff      = {1'b0, frame_r} - {1'b0, evs_q_r};
  assign sel_ch    = ch_r && (stride != 2'd1);
  assign addr_full = 32'(cl_base) + 32'(pos_r) * 32'(stride) + 32'(sel_ch);
  assign smp_ra    = AdrW'(addr_full);
  assign clip_ra   = ClW'(ev_clip);

  assign sneg = smp_q_r[23];
  assign smag = sneg ? (24'd0 - smp_q_r) : smp_q_r;
  assign dq_s = sneg ? (AccW'(0) - AccW'(dquot)) : AccW'(dquot);

  always_comb begin
    dreq.start = (state_r == ST_ADD) && fading_r;
    dreq.mag   = smag;
    dreq.num   = len_r - pos_r;
    dreq.den   = flen_r;
  end

  scm_fade_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .done (ddone),
    .quot (dquot)
  );

  // memory writes and registered reads
  always_ff @(posedge clk) begin
    if (acc_in && in_kind == KIND_SAMPLE)
      smp_mem[AdrW'(in_index)] <= in_sample_value;
    if (acc_in && in_kind == KIND_CLIP && 32'(in_index) < CLIP_SLOTS)
      clip_mem[ClW'(in_index)] <= {in_clip_base, in_clip_frames, in_clip_channels};
    if (acc_in && in_kind == KIND_EVENT && 32'(in_index) < EVENT_SLOTS) begin
      evs_mem[EvW'(in_index)] <= in_event_start;
      evp_mem[EvW'(in_index)] <= {in_event_max_frames, in_event_fade_frames,
                                  in_event_clip, in_event_enable};
    end
    smp_q_r  <= smp_mem[smp_ra];
    clip_q_r <= clip_mem[clip_ra];
    evs_q_r  <= evs_mem[slot_r];
    evp_q_r  <= evp_mem[slot_r];
    en_q_r   <= en_r[slot_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= '0;
    end else if (acc_in && in_kind == KIND_EVENT && 32'(in_index) < EVENT_SLOTS) begin
      en_r[EvW'(in_index)] <= in_event_enable;
    end
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    slot_nxt   = slot_r;
    ch_nxt     = ch_r;
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    flen_nxt   = flen_r;
    fading_nxt = fading_r;
    acc_l_nxt  = acc_l_r;
    acc_r_nxt  = acc_r_r;
    term       = {{(AccW-24){smp_q_r[23]}}, smp_q_r};
    case (state_r)
      ST_IDLE: begin
        if (acc_in && in_kind == KIND_RENDER) begin
          state_nxt = ST_EVRD;
          slot_nxt  = '0;
          acc_l_nxt = '0;
          acc_r_nxt = '0;
        end
      end
      ST_EVRD: state_nxt = ST_CLRD;
      ST_CLRD: state_nxt = ST_CHECK;
      ST_CHECK: begin
        len_nxt    = len_c;
        pos_nxt    = diff[15:0];
        flen_nxt   = (ev_fade < len_c) ? ev_fade : len_c;
        fading_nxt = (ev_fade != 16'd0) &&
                     (diff[15:0] >= len_c - ((ev_fade < len_c) ? ev_fade : len_c));
        ch_nxt     = 1'b0;
        if (en_q_r && 32'(ev_clip) < CLIP_SLOTS && len_c != 16'd0 &&
            !diff[40] && diff[39:0] < 40'(len_c)) begin
          state_nxt = ST_SMPRD;
        end else if (last_slot) begin
          state_nxt = ST_OUT;
        end else begin
          slot_nxt  = slot_r + 1'b1;
          state_nxt = ST_EVRD;
        end
      end
      ST_SMPRD: state_nxt = ST_ADD;
      ST_ADD, ST_DIV: begin
        if (state_r == ST_ADD && fading_r) begin
          state_nxt = ST_DIV;
        end else if (state_r == ST_ADD || ddone) begin
          if (state_r == ST_DIV) term = dq_s;
          if (ch_r) acc_r_nxt = acc_r_r + term;
          else      acc_l_nxt = acc_l_r + term;
          if (!ch_r && OUT_CHANNELS > 1) begin
            ch_nxt    = 1'b1;
            state_nxt = ST_SMPRD;
          end else if (last_slot) begin
            state_nxt = ST_OUT;
          end else begin
            slot_nxt  = slot_r + 1'b1;
            state_nxt = ST_EVRD;
          end
        end
      end
      ST_OUT: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // saturation
  always_comb begin
    sat_l = 1'b0;
    sat_r = 1'b0;
    fin_l = acc_l_r[23:0];
    fin_r = acc_r_r[23:0];
    if ($signed(acc_l_r) > $signed(AccW'(24'sh7fffff))) begin
      fin_l = 24'h7fffff; sat_l = 1'b1;
    end else if ($signed(acc_l_r) < -$signed(AccW'(35'sh800000))) begin
      fin_l = 24'h800000; sat_l = 1'b1;
    end
    if ($signed(acc_r_r) > $signed(AccW'(24'sh7fffff))) begin
      fin_r = 24'h7fffff; sat_r = 1'b1;
    end else if ($signed(acc_r_r) < -$signed(AccW'(35'sh800000))) begin
      fin_r = 24'h800000; sat_r = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load)
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;
    end
    if (acc_in) frame_r <= in_frame_number;
    slot_r   <= slot_nxt;
    ch_r     <= ch_nxt;
    pos_r    <= pos_nxt;
    len_r    <= len_nxt;
    flen_r   <= flen_nxt;
    fading_r <= fading_nxt;
    acc_l_r  <= acc_l_nxt;
    acc_r_r  <= acc_r_nxt;
    if (out_load) begin
      out_l_r   <= fin_l;
      out_r_r   <= fin_r;
      out_sat_r <= sat_l || sat_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_mix_left  = out_l_r;
  assign out_mix_right = out_r_r;
  assign out_saturated = out_sat_r;

endmodule
`default_nettype wire
